### sv/wbwc_pkg.sv
// Package for the word break way counter.
// Request and status codes, default sizes. No dependencies.
`default_nettype none
package wbwc_pkg;
	localparam int unsigned MAX_WORDS_D       = 512;
	localparam int unsigned MAX_WORD_LEN_D    = 8;
	localparam int unsigned MAX_PATTERN_LEN_D = 64;

	typedef enum logic [1:0] {
		REQ_WORD  = 2'd0,
		REQ_PAT   = 2'd1,
		REQ_CLEAR = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_PAT_LONG = 2'd1,
		ST_DICT_OVF = 2'd2
	} status_t;
endpackage
`default_nettype wire

### sv/word_break_way_counter_top.sv
// Word break way counter, top level.
// Depends on wbwc_pkg.
//
// Usage: one command word per handshake, taken on a rising edge with start high
// and busy low. req_type selects: append a dictionary word symbol, append a
// pattern symbol, or clear the dictionary. last marks the final symbol of a
// word or pattern. Word and dictionary-clear commands and non-final pattern
// symbols leave busy low and give no result.
// The final pattern symbol starts the count: a suffix dynamic program over the
// pattern positions, last to first. At each position one shared compare unit
// walks every stored word that fits, symbol by symbol up to a mismatch, each
// after a registered memory read; one shared 64-bit saturating adder accumulates.
// busy stays high until position 0 is done, and done rises in the same cycle
// that busy falls. The result shows on ways/solvable/saturated/status for
// exactly one cycle with done high; the receiver cannot stall. A too-long
// pattern returns status 1 on the next cycle without counting.
// Reset clears word count, load state, overflow flags and pattern length; the
// memories are not cleared, since only written entries are ever used.
`default_nettype none
module word_break_way_counter_top #(
	parameter int unsigned MAX_WORDS       = wbwc_pkg::MAX_WORDS_D,
	parameter int unsigned MAX_WORD_LEN    = wbwc_pkg::MAX_WORD_LEN_D,
	parameter int unsigned MAX_PATTERN_LEN = wbwc_pkg::MAX_PATTERN_LEN_D
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  req_type,
	input  wire logic [7:0]  symbol,
	input  wire logic        last,
	output logic             done,
	output logic [63:0]      ways,
	output logic             solvable,
	output logic             saturated,
	output logic [1:0]       status
);
	import wbwc_pkg::*;

	// widths
	localparam int unsigned W_W   = $clog2(MAX_WORDS + 1);
	localparam int unsigned WA_W  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int unsigned SD    = MAX_WORDS * MAX_WORD_LEN;
	localparam int unsigned SA_W  = (SD > 1) ? $clog2(SD) : 1;
	localparam int unsigned LEN_W = $clog2(MAX_WORD_LEN + 1);
	localparam int unsigned PI_W  = $clog2(MAX_PATTERN_LEN + 1);
	localparam int unsigned PA_W  = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
	localparam int unsigned SUM_W = ((LEN_W > PI_W) ? LEN_W : PI_W) + 1;
	localparam int unsigned PR_W  = W_W + LEN_W;

	localparam logic [W_W-1:0]   MAXW_C = W_W'(MAX_WORDS);
	localparam logic [LEN_W-1:0] MAXL_C = LEN_W'(MAX_WORD_LEN);
	localparam logic [PI_W-1:0]  MAXP_C = PI_W'(MAX_PATTERN_LEN);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_INIT   = 9'b000000010,
		S_POS    = 9'b000000100,
		S_WLEN   = 9'b000001000,
		S_WCHK   = 9'b000010000,
		S_CMP_RD = 9'b000100000,
		S_CMP    = 9'b001000000,
		S_SUM_RD = 9'b010000000,
		S_SUM    = 9'b100000000
	} state_t;

	// memories
	logic [7:0]       word_store    [SD];
	logic [LEN_W-1:0] word_lengths  [MAX_WORDS];
	logic [7:0]       pattern_store [MAX_PATTERN_LEN];
	logic [63:0]      suffix_ways   [MAX_PATTERN_LEN + 1];

	state_t           state_q;
	logic [W_W-1:0]   total_q;
	logic [LEN_W-1:0] ldlen_q;
	logic             dovf_q, dropped_q;
	logic [PI_W-1:0]  plen_q;
	logic             povf_q;
	logic [PI_W-1:0]  pos_q;
	logic [W_W-1:0]   w_q;
	logic [LEN_W-1:0] k_q;
	logic [63:0]      acc_q;

	logic [LEN_W-1:0] len_rd_q;
	logic [7:0]       sym_rd_q, pat_rd_q;
	logic [63:0]      sw_rd_q;

	logic             accept;
	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);

	// word load bookkeeping
	logic             wfull, wlong, wstore, drop_n, wcommit;
	logic [LEN_W-1:0] ldlen_n;
	logic [PR_W-1:0]  ld_addr_w;
	always_comb begin
		wfull     = (total_q >= MAXW_C);
		wlong     = (ldlen_q >= MAXL_C);
		drop_n    = dropped_q || wfull || wlong;
		wstore    = !(wfull || wlong) && !dropped_q;
		ldlen_n   = ldlen_q + LEN_W'(wstore);
		wcommit   = !drop_n && (ldlen_n != '0) && !wfull;
		ld_addr_w = PR_W'(total_q) * PR_W'(MAX_WORD_LEN) + PR_W'(ldlen_q);
	end

	// pattern load
	logic            pfits, povf_n;
	logic [PI_W-1:0] plen_n;
	always_comb begin
		pfits  = (plen_q < MAXP_C);
		plen_n = plen_q + PI_W'(pfits);
		povf_n = povf_q || !pfits;
	end

	// compare unit and shared adder
	logic [SUM_W-1:0] end_pos;
	logic             fits, last_word, adv, pos_end;
	logic [64:0]      sum65;
	logic [63:0]      acc_nxt;
	logic [PR_W-1:0]  cmp_addr_w;
	logic [PI_W-1:0]  pat_idx;
	always_comb begin
		end_pos    = SUM_W'(pos_q) + SUM_W'(len_rd_q);
		fits       = (end_pos <= SUM_W'(plen_q));
		last_word  = ((w_q + W_W'(1)) == total_q);
		sum65      = {1'b0, acc_q} + {1'b0, sw_rd_q};
		cmp_addr_w = PR_W'(w_q) * PR_W'(MAX_WORD_LEN) + PR_W'(k_q);
		pat_idx    = pos_q + PI_W'(k_q);
		acc_nxt    = acc_q;
		adv        = 1'b0;
		case (state_q)
			S_POS: begin
				// empty dictionary: no word fits, position gets zero ways
				adv     = (total_q == '0);
				acc_nxt = '0;
			end
			S_WCHK: adv = !fits;
			S_CMP:  adv = (sym_rd_q != pat_rd_q);
			S_SUM: begin
				adv     = 1'b1;
				acc_nxt = sum65[64] ? '1 : sum65[63:0];
			end
			default: adv = 1'b0;
		endcase
		pos_end = adv && (last_word || (total_q == '0));
	end

	// result strobe: too-long pattern right away, else when position 0 is done
	logic done_n;
	assign done_n = (accept && (req_type == REQ_PAT) && last && povf_n)
		|| (pos_end && (pos_q == '0));

	// memory ports
	always_ff @(posedge clk) begin
		if (accept && (req_type == REQ_WORD) && wstore)
			word_store[ld_addr_w[SA_W-1:0]] <= symbol;
		if (accept && (req_type == REQ_WORD) && last && wcommit)
			word_lengths[total_q[WA_W-1:0]] <= ldlen_n;
		if (accept && (req_type == REQ_PAT) && pfits)
			pattern_store[plen_q[PA_W-1:0]] <= symbol;
		if (state_q == S_INIT)
			suffix_ways[plen_q] <= 64'd1;
		else if (pos_end)
			suffix_ways[pos_q] <= acc_nxt;
		len_rd_q <= word_lengths[w_q[WA_W-1:0]];
		sym_rd_q <= word_store[cmp_addr_w[SA_W-1:0]];
		pat_rd_q <= pattern_store[pat_idx[PA_W-1:0]];
		sw_rd_q  <= suffix_ways[end_pos[PI_W-1:0]];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			total_q   <= '0;
			ldlen_q   <= '0;
			dovf_q    <= 1'b0;
			dropped_q <= 1'b0;
			plen_q    <= '0;
			povf_q    <= 1'b0;
			done      <= 1'b0;
		end else begin
			done <= done_n;
			if (accept) begin
				case (req_type)
					REQ_WORD: begin
						if (wfull || wlong)
							dovf_q <= 1'b1;
						if (last) begin
							ldlen_q   <= '0;
							dropped_q <= 1'b0;
							if (wcommit)
								total_q <= total_q + W_W'(1);
						end else begin
							ldlen_q   <= ldlen_n;
							dropped_q <= drop_n;
						end
					end
					REQ_CLEAR: begin
						total_q   <= '0;
						ldlen_q   <= '0;
						dovf_q    <= 1'b0;
						dropped_q <= 1'b0;
					end
					REQ_PAT: begin
						if (last && povf_n) begin
							plen_q <= '0;
							povf_q <= 1'b0;
						end else begin
							plen_q <= plen_n;
							povf_q <= povf_n;
							if (last)
								state_q <= S_INIT;
						end
					end
					default: begin
					end
				endcase
			end else begin
				case (state_q)
					S_INIT:   state_q <= S_POS;
					S_WLEN:   state_q <= S_WCHK;
					S_CMP_RD: state_q <= S_CMP;
					S_SUM_RD: state_q <= S_SUM;
					S_POS, S_WCHK, S_CMP, S_SUM: begin
						if (pos_end) begin
							if (pos_q == '0) begin
								state_q <= S_IDLE;
								plen_q  <= '0;
								povf_q  <= 1'b0;
							end else begin
								state_q <= S_POS;
							end
						end else if (adv) begin
							state_q <= S_WLEN;
						end else if (state_q == S_WCHK) begin
							state_q <= S_CMP_RD;
						end else if (state_q == S_CMP) begin
							if ((k_q + LEN_W'(1)) == len_rd_q)
								state_q <= S_SUM_RD;
							else
								state_q <= S_CMP_RD;
						end else begin
							state_q <= S_WLEN;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (adv) begin
			acc_q <= acc_nxt;
			w_q   <= w_q + W_W'(1);
			if (pos_end)
				pos_q <= pos_q - PI_W'(1);
		end else begin
			case (state_q)
				S_INIT: pos_q <= plen_q - PI_W'(1);
				S_POS: begin
					w_q   <= '0;
					acc_q <= '0;
				end
				S_WCHK: k_q <= '0;
				S_CMP:  k_q <= k_q + LEN_W'(1);
				default: begin
				end
			endcase
		end
		if (accept && (req_type == REQ_PAT) && last && povf_n) begin
			ways      <= '0;
			solvable  <= 1'b0;
			saturated <= 1'b0;
			status    <= ST_PAT_LONG;
		end else if (pos_end && (pos_q == '0)) begin
			ways      <= acc_nxt;
			solvable  <= (acc_nxt != '0);
			saturated <= (acc_nxt == '1);
			status    <= dovf_q ? ST_DICT_OVF : ST_OK;
		end
	end
endmodule
`default_nettype wire

### test/word_break_checker.sv
// Checker for the word break way counter: predicts the segmentation count per pattern.
// Watches the command and result ports of word_break_way_counter_top; uses wbwc_pkg.
`timescale 1ns / 1ps
module word_break_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [1:0]  req_type,
	input  wire logic [7:0]  symbol,
	input  wire logic        last,
	input  wire logic        done,
	input  wire logic [63:0] ways,
	input  wire logic        solvable,
	input  wire logic        saturated,
	input  wire logic [1:0]  status,
	output int               fails,
	output int               pending
);
	import wbwc_pkg::*;

	localparam int NW = MAX_WORDS_D;
	localparam int WL = MAX_WORD_LEN_D;
	localparam int PL = MAX_PATTERN_LEN_D;

	typedef struct packed {
		logic [63:0] ways;
		logic        solvable;
		logic        saturated;
		status_t     status;
	} outcome_t;

	logic [7:0]  dict_sym [0:NW-1][0:WL-1];
	int          dict_len [0:NW-1];
	int          dict_count;
	int          word_fill;
	bit          dict_ovf;
	bit          word_drop;
	logic [7:0]  pat_sym [0:PL-1];
	int          pat_len;
	bit          pat_ovf;
	outcome_t    outcome_q [$];

	function automatic logic [63:0] sum_sat(logic [63:0] a, logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		return (s < a) ? '1 : s;
	endfunction

	// suffix DP: tail[i] = segmentations of pattern[i..end]
	function automatic logic [63:0] count_ways();
		logic [63:0] tail [0:PL];
		logic [63:0] acc;
		bit          hit;
		tail[pat_len] = 64'd1;
		for (int i = pat_len - 1; i >= 0; i--) begin
			acc = '0;
			for (int w = 0; w < dict_count; w++) begin
				hit = (dict_len[w] <= pat_len - i);
				for (int k = 0; hit && k < dict_len[w]; k++)
					if (dict_sym[w][k] != pat_sym[i + k])
						hit = 0;
				if (hit)
					acc = sum_sat(acc, tail[i + dict_len[w]]);
			end
			tail[i] = acc;
		end
		return tail[0];
	endfunction

	function automatic void take_word_symbol(logic [7:0] s, bit fin);
		if (dict_count >= NW || word_fill >= WL) begin
			dict_ovf  = 1;
			word_drop = 1;
		end else if (!word_drop) begin
			dict_sym[dict_count][word_fill] = s;
			word_fill++;
		end
		if (fin) begin
			if (!word_drop && word_fill > 0 && dict_count < NW) begin
				dict_len[dict_count] = word_fill;
				dict_count++;
			end
			word_fill = 0;
			word_drop = 0;
		end
	endfunction

	function automatic void take_pattern_symbol(logic [7:0] s, bit fin);
		outcome_t o;
		if (pat_len < PL) begin
			pat_sym[pat_len] = s;
			pat_len++;
		end else
			pat_ovf = 1;
		if (!fin)
			return;
		if (pat_ovf)
			o = '{ways: '0, solvable: 0, saturated: 0, status: ST_PAT_LONG};
		else begin
			o.ways      = count_ways();
			o.solvable  = (o.ways != 0);
			o.saturated = (o.ways == '1);
			o.status    = dict_ovf ? ST_DICT_OVF : ST_OK;
		end
		outcome_q = {outcome_q, o};
		pat_len = 0;
		pat_ovf = 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t e;
		if (!arst_n) begin
			dict_count = 0;
			word_fill  = 0;
			dict_ovf   = 0;
			word_drop  = 0;
			pat_len    = 0;
			pat_ovf    = 0;
			fails      = 0;
			outcome_q.delete();
		end else begin
			// result first: a word accepted on this edge cannot have produced it
			if (done) begin
				if (outcome_q.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected result: ways=%0d status=%0d", ways, status);
				end else begin
					e = outcome_q.pop_front();
					if (ways !== e.ways || solvable !== e.solvable
							|| saturated !== e.saturated || status !== e.status) begin
						fails++;
						if (fails <= 10)
							$display("mismatch: exp %0d/%0b/%0b/%0d got %0d/%0b/%0b/%0d",
								e.ways, e.solvable, e.saturated, e.status,
								ways, solvable, saturated, status);
					end
				end
			end
			if (start && !busy) begin
				case (req_type)
					REQ_WORD:  take_word_symbol(symbol, last);
					REQ_PAT:   take_pattern_symbol(symbol, last);
					REQ_CLEAR: begin
						dict_count = 0;
						word_fill  = 0;
						dict_ovf   = 0;
						word_drop  = 0;
					end
					default: ;
				endcase
			end
		end
		pending = outcome_q.size();
	end
endmodule

### test/testbench.sv
// Testbench top for the word break way counter: drives command words, gives the verdict.
// Depends on wbwc_pkg, word_break_way_counter_top and word_break_checker.
`timescale 1ns / 1ps
module testbench;
	import wbwc_pkg::*;

	localparam int LIMIT = 20000000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  req_type;
	logic [7:0]  symbol;
	logic        last;
	logic        done;
	logic [63:0] ways;
	logic        solvable;
	logic        saturated;
	logic [1:0]  status;
	int          fails;
	int          pending;
	int          cycles;
	int          sent;
	bit          idle_on;

	// mirror of the words known to be in the dictionary, for building patterns
	logic [7:0]  known_sym [0:63][0:7];
	int          known_len [0:63];
	int          known_cnt;

	word_break_way_counter_top u_top (
		.clk, .arst_n, .start, .busy, .req_type, .symbol, .last,
		.done, .ways, .solvable, .saturated, .status
	);

	word_break_checker u_chk (
		.clk, .arst_n, .start, .busy, .req_type, .symbol, .last,
		.done, .ways, .solvable, .saturated, .status, .fails, .pending
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// cycle limit: timeout is a failure
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// pause: hold start low, setting it at each falling edge
	task automatic quiet(int n);
		repeat (n) begin
			@(negedge clk);
			start = 0;
		end
	endtask

	// present one word and wait for the handshake; start stays high afterwards
	// so back-to-back words have no gap. Anything else must begin with quiet().
	// busy is checked at the falling edge, where it is stable for the next rise.
	task automatic send(logic [1:0] r, logic [7:0] s, bit l);
		@(negedge clk);
		start    = 1;
		req_type = r;
		symbol   = s;
		last     = l;
		while (busy)
			@(negedge clk);
		@(posedge clk);
		sent++;
		if (idle_on && $urandom_range(0, 5) == 0)
			quiet($urandom_range(1, 12));
	endtask

	// pause until every expected result has come back
	task automatic drain();
		quiet(1);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic clear_dict();
		send(REQ_CLEAR, 8'($urandom), 1'($urandom_range(0, 1)));
		known_cnt = 0;
	endtask

	// random word over a two-letter alphabet, sometimes odd bytes or too long
	task automatic random_word();
		int n;
		logic [7:0] c;
		n = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
		for (int j = 0; j < n; j++) begin
			c = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'("a" + $urandom_range(0, 1));
			if (j < 8 && known_cnt < 64)
				known_sym[known_cnt][j] = c;
			send(REQ_WORD, c, j == n - 1);
		end
		if (n <= 8 && known_cnt < 64) begin
			known_len[known_cnt] = n;
			known_cnt++;
		end
	endtask

	// pattern mostly built from known words; sometimes broken or too long
	task automatic random_pattern();
		logic [7:0] p [0:79];
		int n, target, w;
		n = 0;
		if ($urandom_range(0, 39) == 0)
			target = $urandom_range(60, 70);
		else
			target = $urandom_range(1, 20);
		while (n < target) begin
			if (known_cnt == 0 || $urandom_range(0, 7) == 0) begin
				p[n] = 8'("a" + $urandom_range(0, 1));
				n++;
			end else begin
				w = $urandom_range(0, known_cnt - 1);
				for (int k = 0; k < known_len[w] && n < 80; k++) begin
					p[n] = known_sym[w][k];
					n++;
				end
			end
		end
		if ($urandom_range(0, 9) == 0)
			p[$urandom_range(0, n - 1)] = 8'($urandom);
		for (int i = 0; i < n; i++)
			send(REQ_PAT, p[i], i == n - 1);
	endtask

	initial begin
		start    = 0;
		req_type = REQ_WORD;
		symbol   = '0;
		last     = 0;
		arst_n   = 0;
		cycles   = 0;
		sent     = 0;
		idle_on  = 1;
		known_cnt = 0;
		repeat (10) @(negedge clk);
		arst_n = 1;

		// --- directed ---
		// empty dictionary: no way
		send(REQ_PAT, 8'h00, 1);
		// two copies of "a": 2^63 for 63 symbols, saturation at 64
		send(REQ_WORD, "a", 1);
		send(REQ_WORD, "a", 1);
		for (int i = 0; i < 63; i++) send(REQ_PAT, "a", i == 62);
		for (int i = 0; i < 64; i++) send(REQ_PAT, "a", i == 63);
		// pattern too long
		for (int i = 0; i < 66; i++) send(REQ_PAT, "a", i == 65);
		// ignored request type 3
		send(2'd3, 8'hFF, 1);
		// extreme bytes as a word, unfinished word before a pattern ends
		send(REQ_WORD, 8'hFF, 0);
		send(REQ_WORD, 8'h00, 1);
		send(REQ_WORD, 8'hFF, 0);
		send(REQ_PAT, 8'hFF, 0);
		send(REQ_PAT, 8'h00, 1);
		// word too long sets dictionary overflow
		for (int i = 0; i < 9; i++) send(REQ_WORD, "b", i == 8);
		send(REQ_PAT, "a", 1);
		// pattern too long beats dictionary overflow
		for (int i = 0; i < 65; i++) send(REQ_PAT, "b", i == 64);
		drain();
		clear_dict();
		send(REQ_PAT, "a", 1);
		// full dictionary, then one word too many
		for (int i = 0; i < MAX_WORDS_D; i++) send(REQ_WORD, "a", 1);
		send(REQ_PAT, "a", 1);
		send(REQ_WORD, "c", 1);
		send(REQ_PAT, "a", 0);
		send(REQ_PAT, "a", 1);
		drain();
		clear_dict();

		// --- random ---
		while (sent < 2000) begin
			if (sent > 1700)
				idle_on = 0;
			if (known_cnt > 14 || $urandom_range(0, 5) == 0)
				clear_dict();
			repeat ($urandom_range(0, 4)) random_word();
			if ($urandom_range(0, 15) == 0)
				send(2'd3, 8'($urandom), 1'($urandom_range(0, 1)));
			random_pattern();
			if ($urandom_range(0, 30) == 0)
				drain();
		end

		drain();
		quiet(200);
		if (fails == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end
endmodule

### filelist.f
sv/wbwc_pkg.sv
sv/word_break_way_counter_top.sv
test/word_break_checker.sv
test/testbench.sv
